### rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

### rtl/lu_pkg.sv
// Package: widths, types and fixed-point helpers of the 3x3 LU solver.
package lu_pkg;
  localparam int FracBits = 16;
  localparam int WordBits = 32;
  localparam int Dim = 3;
  localparam int ProdBits = 2 * WordBits;
  localparam int AccBits = WordBits + 2;
  localparam int DivNumBits = WordBits + FracBits;
  localparam int DivCntBits = $clog2(DivNumBits + 1);
  localparam int QDepth = 2;

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct packed {
    word_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
    word_t b0, b1, b2;
  } sys_t;

  typedef enum logic [4:0] {
    S_IDLE, S_U01, S_U02, S_L11, S_L21, S_U12, S_L22,
    S_Y0, S_Y1, S_Y2, S_X1, S_X0, S_OUT, S_SING,
    S_MUL, S_DIV
  } state_e;

  function automatic word_t sat_w(input logic signed [ProdBits+1:0] v);
    logic signed [ProdBits+1:0] hi, lo;
    begin
      hi = (ProdBits+2)'((64'sd1 <<< (WordBits - 1)) - 64'sd1);
      lo = -hi - (ProdBits+2)'(1);
      if (v > hi) sat_w = word_t'(hi);
      else if (v < lo) sat_w = word_t'(lo);
      else sat_w = word_t'(v);
    end
  endfunction
endpackage

### rtl/lu_front.sv
// Front end: collects three rows and pushes a complete system into the queue.
module lu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lu_pkg::word_t    coef_0_i,
  input  lu_pkg::word_t    coef_1_i,
  input  lu_pkg::word_t    coef_2_i,
  input  lu_pkg::word_t    rhs_i,
  output logic             push_o,
  output lu_pkg::sys_t     sys_o,
  input  logic             full_i
);
  import lu_pkg::*;
  logic [1:0] row_q, row_d;
  sys_t sys_q, sys_d;
  logic acc;

  assign in_stall_o = full_i;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    row_d = row_q;
    sys_d = sys_q;
    if (acc) begin
      case (row_q)
        2'd0: begin
          sys_d.a00 = coef_0_i; sys_d.a01 = coef_1_i; sys_d.a02 = coef_2_i;
          sys_d.b0 = rhs_i; row_d = 2'd1;
        end
        2'd1: begin
          sys_d.a10 = coef_0_i; sys_d.a11 = coef_1_i; sys_d.a12 = coef_2_i;
          sys_d.b1 = rhs_i; row_d = 2'd2;
        end
        default: begin
          sys_d.a20 = coef_0_i; sys_d.a21 = coef_1_i; sys_d.a22 = coef_2_i;
          sys_d.b2 = rhs_i; row_d = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_q <= 2'd0;
    else row_q <= row_d;
  end

  always_ff @(posedge clk_i) sys_q <= sys_d;

  assign push_o = acc && (row_q == 2'd2);
  assign sys_o = sys_d;
endmodule

### rtl/lu_queue.sv
// Two-entry queue of complete systems between front and back.
module lu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lu_pkg::sys_t  data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output lu_pkg::sys_t  data_o
);
  import lu_pkg::*;
  sys_t mem_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'(QDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o, "queue underflow")
  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'(QDepth), "queue count out of range")
endmodule

### rtl/lu_back.sv
// Back end: sequencer with shared multiplier and radix-2 divider.
module lu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  lu_pkg::sys_t   sys_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lu_pkg::word_t  x_0_o,
  output lu_pkg::word_t  x_1_o,
  output lu_pkg::word_t  x_2_o,
  output logic           singular_o
);
  import lu_pkg::*;
  state_e st_q, st_d, ret_q, ret_d;
  logic [1:0] ph_q, ph_d;
  logic [1:0] mph_q;
  word_t l11_q, l21_q, l22_q, u01_q, u02_q, u12_q, y0_q, y1_q, y2_q, x0_q, x1_q;
  // sum kept exact across both subtractions, saturated once on use
  logic signed [AccBits-1:0] acc_q;
  word_t ma_q, mb_q;
  logic signed [ProdBits-1:0] mp_q;
  // divider
  logic [DivNumBits-1:0] dn_q, dq_q;
  logic [WordBits-1:0] dd_q;
  logic [WordBits:0] dr_q;
  logic dneg_q;
  logic [DivCntBits-1:0] dc_q;
  word_t dres;
  word_t mres;
  logic ov_q;
  word_t ox0_q, ox1_q, ox2_q;
  logic osing_q;

  logic start_mul, start_div;
  logic mul_done, div_done;
  word_t sel_a, sel_b;
  logic signed [AccBits-1:0] sel_acc;
  logic [WordBits:0] trial;
  logic [WordBits:0] dsh;

  function automatic logic [WordBits-1:0] mag(input word_t v);
    mag = v[WordBits-1] ? WordBits'(-v) : WordBits'(v);
  endfunction

  // product after the shift, saturated
  function automatic word_t mulsat(input logic signed [ProdBits-1:0] p);
    logic signed [ProdBits+1:0] s;
    logic neg;
    logic [ProdBits-1:0] m;
    begin
      neg = p[ProdBits-1];
      m = neg ? ProdBits'(-p) : ProdBits'(p);
      m = m >> FracBits;
      s = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
      mulsat = sat_w(s);
    end
  endfunction

  // quotient magnitude to saturated signed word
  always_comb begin
    logic [DivNumBits-1:0] lim;
    lim = DivNumBits'((64'd1 << (WordBits - 1)) - (dneg_q ? 64'd0 : 64'd1));
    if (dd_q == '0) dres = '0;
    else if (dq_q > lim) dres = dneg_q ? word_t'(-lim) : word_t'(lim);
    else dres = dneg_q ? word_t'(-dq_q) : word_t'(dq_q);
  end

  assign dsh = {dr_q[WordBits-1:0], dn_q[DivNumBits-1]};
  assign trial = dsh - {1'b0, dd_q};
  assign mres = sat_w((ProdBits+2)'(acc_q) - (ProdBits+2)'(mulsat(mp_q)));

  // next state; each op goes to MUL or DIV and returns
  always_comb begin
    st_d = st_q; ret_d = ret_q; ph_d = ph_q;
    case (st_q)
      S_IDLE: if (q_valid_i && !ov_q) begin
        if (sys_i.a00 == '0) st_d = S_SING;
        else begin
          st_d = S_DIV; ret_d = S_U01;
        end
      end
      S_U01: begin
        st_d = S_DIV; ret_d = S_U02;
      end
      S_U02: begin
        st_d = S_MUL; ret_d = S_L11; ph_d = 2'd0;
      end
      S_L11: begin
        st_d = S_MUL; ret_d = S_L21;
      end
      S_L21: if (l11_q == '0) st_d = S_SING;
      else begin
        st_d = S_MUL; ret_d = S_U12;
      end
      S_U12: begin
        if (ph_q == 2'd0) begin
          st_d = S_DIV; ret_d = S_U12; ph_d = 2'd1;
        end else begin
          st_d = S_MUL; ret_d = S_L22; ph_d = 2'd0;
        end
      end
      S_L22: begin
        if (ph_q == 2'd0) begin
          st_d = S_MUL; ret_d = S_L22; ph_d = 2'd1;
        end else if (l22_q == '0) st_d = S_SING;
        else begin
          st_d = S_DIV; ret_d = S_Y0; ph_d = 2'd0;
        end
      end
      S_Y0: begin
        st_d = S_MUL; ret_d = S_Y1; ph_d = 2'd0;
      end
      S_Y1: begin
        if (ph_q == 2'd0) begin
          st_d = S_DIV; ret_d = S_Y1; ph_d = 2'd1;
        end else begin
          st_d = S_MUL; ret_d = S_Y2; ph_d = 2'd0;
        end
      end
      S_Y2: begin
        if (ph_q == 2'd0) begin
          st_d = S_MUL; ret_d = S_Y2; ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          st_d = S_DIV; ret_d = S_Y2; ph_d = 2'd2;
        end else begin
          st_d = S_MUL; ret_d = S_X1; ph_d = 2'd0;
        end
      end
      S_X1: begin
        st_d = S_MUL; ret_d = S_X0; ph_d = 2'd0;
      end
      S_X0: begin
        if (ph_q == 2'd0) begin
          st_d = S_MUL; ret_d = S_X0; ph_d = 2'd1;
        end else st_d = S_OUT;
      end
      S_OUT, S_SING: st_d = S_IDLE;
      S_MUL: if (mph_q == 2'd2) st_d = ret_q;
      S_DIV: if (dc_q == '0) st_d = ret_q;
      default: st_d = S_IDLE;
    endcase
  end

  // operand selection and unit starts
  always_comb begin
    start_mul = 1'b0; start_div = 1'b0; pop_o = 1'b0;
    sel_a = '0; sel_b = '0; sel_acc = acc_q;
    case (st_q)
      S_IDLE: if (q_valid_i && !ov_q && sys_i.a00 != '0) begin
        start_div = 1'b1; sel_a = sys_i.a01; sel_b = sys_i.a00;
      end
      S_U01: begin
        start_div = 1'b1; sel_a = sys_i.a02; sel_b = sys_i.a00;
      end
      S_U02: begin
        start_mul = 1'b1; sel_a = sys_i.a10; sel_b = u01_q; sel_acc = AccBits'(sys_i.a11);
      end
      S_L11: begin
        start_mul = 1'b1; sel_a = sys_i.a20; sel_b = u01_q; sel_acc = AccBits'(sys_i.a21);
      end
      S_L21: if (l11_q != '0) begin
        start_mul = 1'b1; sel_a = sys_i.a10; sel_b = u02_q; sel_acc = AccBits'(sys_i.a12);
      end
      S_U12: begin
        if (ph_q == 2'd0) begin
          start_div = 1'b1; sel_a = sat_w((ProdBits+2)'(acc_q)); sel_b = l11_q;
        end else begin
          start_mul = 1'b1; sel_a = sys_i.a20; sel_b = u02_q; sel_acc = AccBits'(sys_i.a22);
        end
      end
      S_L22: begin
        if (ph_q == 2'd0) begin
          start_mul = 1'b1; sel_a = l21_q; sel_b = u12_q;
        end else if (l22_q != '0) begin
          start_div = 1'b1; sel_a = sys_i.b0; sel_b = sys_i.a00;
        end
      end
      S_Y0: begin
        start_mul = 1'b1; sel_a = sys_i.a10; sel_b = y0_q; sel_acc = AccBits'(sys_i.b1);
      end
      S_Y1: begin
        if (ph_q == 2'd0) begin
          start_div = 1'b1; sel_a = sat_w((ProdBits+2)'(acc_q)); sel_b = l11_q;
        end else begin
          start_mul = 1'b1; sel_a = sys_i.a20; sel_b = y0_q; sel_acc = AccBits'(sys_i.b2);
        end
      end
      S_Y2: begin
        if (ph_q == 2'd0) begin
          start_mul = 1'b1; sel_a = l21_q; sel_b = y1_q;
        end else if (ph_q == 2'd1) begin
          start_div = 1'b1; sel_a = sat_w((ProdBits+2)'(acc_q)); sel_b = l22_q;
        end else begin
          start_mul = 1'b1; sel_a = u12_q; sel_b = y2_q; sel_acc = AccBits'(y1_q);
        end
      end
      S_X1: begin
        start_mul = 1'b1; sel_a = u02_q; sel_b = y2_q; sel_acc = AccBits'(y0_q);
      end
      S_X0: if (ph_q == 2'd0) begin
        start_mul = 1'b1; sel_a = u01_q; sel_b = x1_q;
      end
      S_OUT, S_SING: pop_o = 1'b1;
      default: ;
    endcase
  end

  // multiply unit steps: register operands, product, saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_IDLE; ph_q <= 2'd0; mph_q <= 2'd0; dc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; ph_q <= ph_d;
      if (start_mul) mph_q <= 2'd0;
      else if (st_q == S_MUL) mph_q <= mph_q + 2'd1;
      if (start_div) dc_q <= DivCntBits'(DivNumBits);
      else if (dc_q != '0) dc_q <= dc_q - DivCntBits'(1);
      if (st_q == S_OUT || st_q == S_SING) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
    end
  end

  // result write-back on return from a unit
  assign mul_done = (st_q == S_MUL) && (mph_q == 2'd2);
  assign div_done = (st_q == S_DIV) && (dc_q == '0);

  always_ff @(posedge clk_i) begin
    if (start_mul) begin
      ma_q <= sel_a; mb_q <= sel_b; acc_q <= sel_acc;
    end else if (mul_done) begin
      acc_q <= acc_q - AccBits'(mulsat(mp_q));
    end
    mp_q <= ma_q * mb_q;
    if (start_div) begin
      dn_q <= {mag(sel_a), FracBits'(0)};
      dd_q <= mag(sel_b);
      dneg_q <= sel_a[WordBits-1] ^ sel_b[WordBits-1];
      dr_q <= '0; dq_q <= '0;
    end else if (dc_q != '0) begin
      dn_q <= dn_q << 1;
      if (!trial[WordBits]) begin
        dr_q <= trial; dq_q <= {dq_q[DivNumBits-2:0], 1'b1};
      end else begin
        dr_q <= dsh; dq_q <= {dq_q[DivNumBits-2:0], 1'b0};
      end
    end
    if (div_done) begin
      case (ret_q)
        S_U01: u01_q <= dres;
        S_U02: u02_q <= dres;
        S_U12: u12_q <= dres;
        S_Y0: y0_q <= dres;
        S_Y1: y1_q <= dres;
        S_Y2: y2_q <= dres;
        default: ;
      endcase
    end
    if (mul_done) begin
      case (ret_q)
        S_L11: l11_q <= mres;
        S_L21: l21_q <= mres;
        S_X1: x1_q <= mres;
        default: ;
      endcase
      if (ret_q == S_L22 && ph_q == 2'd1) l22_q <= mres;
      if (ret_q == S_X0 && ph_q == 2'd1) x0_q <= mres;
    end
    if (st_q == S_OUT) begin
      ox0_q <= x0_q; ox1_q <= x1_q; ox2_q <= y2_q; osing_q <= 1'b0;
    end else if (st_q == S_SING) begin
      ox0_q <= '0; ox1_q <= '0; ox2_q <= '0; osing_q <= 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign x_0_o = ox0_q;
  assign x_1_o = ox1_q;
  assign x_2_o = ox2_q;
  assign singular_o = osing_q;

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_pop_idle, clk_i, rst_ni, pop_o && !q_valid_i, "pop without system")
  `ASSERT_NEVER(a_busy_out, clk_i, rst_ni, pop_o && ov_q, "result overwritten")
  `ASSERT_NEVER(a_div_zero, clk_i, rst_ni, start_div && sel_b == '0, "division by zero pivot")
endmodule

### rtl/lu_linear_solver_3x3_top.sv
// Top level of the 3x3 LU linear solver.
// channel | valid       | stall        | payload
// in      | in_valid_i  | in_stall_o   | coef_0_i coef_1_i coef_2_i rhs_i
// out     | out_valid_o | out_stall_i  | x_0_o x_1_o x_2_o singular_o
// Rows one and two are stored; the third row pushes the system into the queue.
// When the back end is free, a solve runs six serial divisions, eleven
// multiplies and 19 sequencer steps before the result is valid.
// Zero pivot ends the solve early with the singular flag.
// Reset clears row count, queue and sequencer; stores need no clearing.
// A two-entry queue lets rows of the next system load while one solves.
module lu_linear_solver_3x3_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lu_pkg::word_t  coef_0_i,
  input  lu_pkg::word_t  coef_1_i,
  input  lu_pkg::word_t  coef_2_i,
  input  lu_pkg::word_t  rhs_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lu_pkg::word_t  x_0_o,
  output lu_pkg::word_t  x_1_o,
  output lu_pkg::word_t  x_2_o,
  output logic           singular_o
);
  import lu_pkg::*;
  logic push, full, qv, pop;
  sys_t sys_in, sys_out;

  lu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .coef_0_i, .coef_1_i, .coef_2_i,
    .rhs_i, .push_o(push), .sys_o(sys_in), .full_i(full)
  );
  lu_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(sys_in), .full_o(full),
    .valid_o(qv), .pop_i(pop), .data_o(sys_out)
  );
  lu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .sys_i(sys_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .x_0_o, .x_1_o, .x_2_o, .singular_o
  );
endmodule
